FILE: hw/rtl/stack_with_middle_access_assert.svh
// Assertion macros used by the stack datapath module.
`ifndef STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH
`define STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`endif

FILE: hw/rtl/swm_pkg.sv
// Shared types and codes for the stack with middle access.
package swm_pkg;

    // Request codes carried on the mode port.
    localparam logic [1:0] MODE_PUSH       = 2'd0;
    localparam logic [1:0] MODE_POP        = 2'd1;
    localparam logic [1:0] MODE_READ_MID   = 2'd2;
    localparam logic [1:0] MODE_DELETE_MID = 2'd3;

    // Status codes returned with each result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Width of the fixed result ports.
    localparam int READ_W  = 32;
    localparam int COUNT_W = 5;

    // Which result the datapath loads when it emits.
    typedef enum logic [1:0] {
        RES_OK_ZERO,
        RES_EMPTY,
        RES_FULL,
        RES_DATA
    } swm_res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         push_wr;
        logic         rd_top;
        logic         rd_mid;
        logic         set_ptr_mid;
        logic         rd_next;
        logic         wr_shift;
        logic         dec_count;
        logic         emit;
        swm_res_sel_t res_sel;
    } swm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic more_shift;
    } swm_stat_t;

endpackage

FILE: hw/rtl/stack_with_middle_access.sv
// Push, pop, read middle and delete middle with a single-port entry memory.
// Push, and any request that finds the stack empty: result in the cycle after accept.
// Pop and read middle: registered memory read, then loaded in the result registers.
// Delete middle: the n - 1 - n/2 entries above the middle, n the count before, each
// move down one place by a memory read and a write; then the count drops with the result.
// Requests taken only when idle; busy drops with the result; reset spares memory and data.
module stack_with_middle_access
    import swm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic signed [READ_W-1:0]  push_value,
    output logic                      done,
    output logic signed [READ_W-1:0]  read_value,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty
);

    swm_cmd_t  cmd;
    swm_stat_t stat;

    // Sequencing of each transaction.
    swm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Storage and result registers.
    swm_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_value  (push_value),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule

FILE: hw/rtl/swm_ctrl.sv
// Controller state machine that sequences each stack transaction.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  swm_stat_t  stat,
    output logic       busy,
    output swm_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_PUSH)
                    begin
                        cmd.emit = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res_sel = RES_FULL;
                        end
                        else
                        begin
                            cmd.push_wr = 1'b1;
                            cmd.res_sel = RES_OK_ZERO;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_EMPTY;
                    end
                    else
                    begin
                        case (mode)
                            MODE_POP:
                            begin
                                cmd.rd_top = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                            MODE_READ_MID:
                            begin
                                cmd.rd_mid = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                            MODE_DELETE_MID:
                            begin
                                cmd.set_ptr_mid = 1'b1;
                                state_next      = S_SHIFT_RD;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_READ_WAIT:
            begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_DATA;
                state_next  = S_IDLE;
            end
            S_SHIFT_RD:
            begin
                if (stat.more_shift)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.res_sel   = RES_OK_ZERO;
                    state_next    = S_IDLE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hw/rtl/swm_datapath.sv
// Datapath: entry memory, count, shift pointer and result registers.
module swm_datapath
    import swm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [READ_W-1:0]  push_value,
    input  swm_cmd_t                  cmd,
    output swm_stat_t                 stat,
    output logic                      done,
    output logic signed [READ_W-1:0]  read_value,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]        mem [DEPTH];
    logic [DATA_WIDTH-1:0]        rdata_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [AW-1:0]                ptr_reg;
    logic [AW-1:0]                ptr_next;
    logic                         done_reg;
    logic [READ_W-1:0]            read_value_reg;
    logic [1:0]                   status_reg;
    logic [COUNT_W-1:0]           entry_count_reg;
    logic                         is_empty_reg;

    logic [CW-1:0]                count_m1;
    logic [CW-1:0]                count_half;
    logic [CW-1:0]                ptr_inc;
    logic [DATA_WIDTH+READ_W-1:0] push_wide;
    logic [DATA_WIDTH-1:0]        push_word;
    logic [DATA_WIDTH+READ_W-1:0] rdata_wide;
    logic [CW+COUNT_W-1:0]        count_wide;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DATA_WIDTH-1:0]        wr_data;

    // Address arithmetic on the count and shift pointer.
    assign count_m1   = count_reg - CW'(1);
    assign count_half = count_reg >> 1;
    assign ptr_inc    = CW'(ptr_reg) + CW'(1);

    // Width adaptation between the 32-bit ports and the stored word.
    assign push_wide  = {{DATA_WIDTH{1'b0}}, push_value};
    assign push_word  = push_wide[DATA_WIDTH-1:0];
    assign rdata_wide = {{READ_W{1'b0}}, rdata_reg};

    // Status back to the controller.
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.more_shift = (ptr_inc < count_reg);

    // Memory port selection.
    always_comb
    begin
        rd_en = cmd.rd_top | cmd.rd_mid | cmd.rd_next;
        if (cmd.rd_top)
        begin
            rd_addr = count_m1[AW-1:0];
        end
        else if (cmd.rd_mid)
        begin
            rd_addr = count_half[AW-1:0];
        end
        else
        begin
            rd_addr = ptr_inc[AW-1:0];
        end
        wr_en   = cmd.push_wr | cmd.wr_shift;
        wr_addr = cmd.push_wr ? count_reg[AW-1:0] : ptr_reg;
        wr_data = cmd.push_wr ? push_word : rdata_reg;
    end

    // Entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Next count and shift pointer.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.rd_top || cmd.dec_count)
        begin
            count_next = count_m1;
        end
        ptr_next = ptr_reg;
        if (cmd.set_ptr_mid)
        begin
            ptr_next = count_half[AW-1:0];
        end
        else if (cmd.wr_shift)
        begin
            ptr_next = ptr_inc[AW-1:0];
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    // Count, pointer and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= cmd.emit;
        end
    end

    // Result payload, loaded when a transaction completes.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            entry_count_reg <= count_wide[COUNT_W-1:0];
            is_empty_reg    <= (count_next == '0);
            case (cmd.res_sel)
                RES_OK_ZERO:
                begin
                    read_value_reg <= '0;
                    status_reg     <= ST_OK;
                end
                RES_EMPTY:
                begin
                    read_value_reg <= '1;
                    status_reg     <= ST_EMPTY;
                end
                RES_FULL:
                begin
                    read_value_reg <= '0;
                    status_reg     <= ST_FULL;
                end
                RES_DATA:
                begin
                    read_value_reg <= rdata_wide[READ_W-1:0];
                    status_reg     <= ST_OK;
                end
                default:
                begin
                    read_value_reg <= '0;
                    status_reg     <= ST_OK;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;

`include "stack_with_middle_access_assert.svh"

    // The count never exceeds the capacity.
    `SWM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    // A push is written only when there is room for it.
    `SWM_ASSERT_NOW(a_push_has_room, cmd.push_wr, !stat.full)
    // A shift write stays below the top entry.
    `SWM_ASSERT_NOW(a_shift_in_range, cmd.wr_shift, ptr_inc < count_reg)
    // Moving an entry down leaves the count alone.
    `SWM_ASSERT_NEXT(a_shift_keeps_count, cmd.wr_shift, count_reg == $past(count_reg))
    // An empty result carries all ones and reports no entries.
    `SWM_ASSERT_NOW(a_empty_result, done_reg && (status_reg == ST_EMPTY),
        (read_value_reg == '1) && is_empty_reg)

endmodule
